// File: rtl/oahi_pkg.sv
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared constants, register map and small helpers for the open-addressing
// hash insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package oahi_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_PROBES  = 6;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int PROBE_W     = $clog2(MAX_PROBES + 1);

  // field widths
  localparam int KEY_W   = 31;
  localparam int MOD_W   = 16;
  localparam int COUNT_W = 5;
  localparam int MODE_W  = 2;
  localparam int TSIZE_W = 5;

  // probe modes
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_PROBE_MODE     = 2'd0;
  localparam logic [1:0] REG_TABLE_SIZE     = 2'd1;
  localparam logic [1:0] REG_SECOND_MODULUS = 2'd2;

  // reset values
  localparam logic [MODE_W-1:0]  PROBE_MODE_RST = MODE_LINEAR;
  localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = 5'd16;
  localparam logic [MOD_W-1:0]   SECOND_MOD_RST = 16'd7;

  // slot count in use: zero reads as one, large values clamp to the depth
  function automatic logic [SIZE_W-1:0] eff_size(input logic [TSIZE_W-1:0] ts);
    logic [SIZE_W-1:0] s;
    if (ts == '0) begin
      s = SIZE_W'(1);
    end else if (32'(ts) > TABLE_DEPTH) begin
      s = SIZE_W'(TABLE_DEPTH);
    end else begin
      s = SIZE_W'(ts);
    end
    return s;
  endfunction

  // (a + b) mod s for a, b already below s
  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b,
                                               input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] sum;
    sum = (SIZE_W+1)'(a) + (SIZE_W+1)'(b);
    if (sum >= (SIZE_W+1)'(s)) begin
      sum = sum - (SIZE_W+1)'(s);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/open_addressing_hash_insert_top.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_top
// Open-addressing hash table insert with linear, quadratic or double-hashing
// probing, a shared bit-serial remainder unit and a per-slot occupancy map.
// ----------------------------------------------------------------------------
// One key is worked on at a time. A single restoring remainder unit, one
// quotient bit per cycle over the 31-bit key, finds key mod size; in
// double-hashing mode it runs twice more, for key mod R and for the step
// mod size. Probes follow, up to six, one after another, and the item is
// then moved to the output register once that is free. The key input is
// ready again from the edge that loads the result, also while it waits to
// be taken. The occupancy map is cleared by reset at once; keys are not
// retained.
`default_nettype none

module open_addressing_hash_insert_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [3:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output      logic [31:0]                       prdata,
  output      logic                              pready,
  // key items
  input  wire logic                              key_valid,
  output      logic                              key_ready,
  input  wire logic [oahi_pkg::KEY_W-1:0]        key,
  // result items
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              inserted,
  output      logic [oahi_pkg::IDX_W-1:0]        slot,
  output      logic [oahi_pkg::PROBE_W-1:0]      collisions,
  output      logic [oahi_pkg::COUNT_W-1:0]      stored_count
);

  // sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_PROBE  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  // remainder unit passes
  localparam logic [1:0] PH_HOME = 2'd0;
  localparam logic [1:0] PH_KEYR = 2'd1;
  localparam logic [1:0] PH_STEP = 2'd2;

  localparam int                 DIV_W    = $clog2(oahi_pkg::KEY_W);
  localparam logic [DIV_W-1:0]   DIV_LAST = DIV_W'(oahi_pkg::KEY_W - 1);
  localparam logic [oahi_pkg::PROBE_W-1:0] PROBE_LAST =
    oahi_pkg::PROBE_W'(oahi_pkg::MAX_PROBES - 1);
  localparam logic [oahi_pkg::PROBE_W-1:0] PROBE_ALL =
    oahi_pkg::PROBE_W'(oahi_pkg::MAX_PROBES);

  // configuration registers
  logic [oahi_pkg::MODE_W-1:0]  probe_mode;
  logic [oahi_pkg::TSIZE_W-1:0] table_size;
  logic [oahi_pkg::MOD_W-1:0]   second_modulus;

  // sequencer and per-item state
  logic [1:0]                    state;
  logic [1:0]                    phase;
  logic [oahi_pkg::KEY_W-1:0]    key_q;
  logic [oahi_pkg::SIZE_W-1:0]   size_q;
  logic [oahi_pkg::IDX_W-1:0]    idx;
  logic [oahi_pkg::IDX_W-1:0]    delta;
  logic [oahi_pkg::PROBE_W-1:0]  probe_i;
  logic [oahi_pkg::PROBE_W-1:0]  hits;

  // remainder unit
  logic [oahi_pkg::MOD_W-1:0]    div_rem;
  logic [oahi_pkg::KEY_W-1:0]    div_dvd;
  logic [oahi_pkg::MOD_W-1:0]    div_sor;
  logic [DIV_W-1:0]              div_cnt;

  // table state
  logic [oahi_pkg::TABLE_DEPTH-1:0] slot_valid;
  logic [oahi_pkg::COUNT_W-1:0]     key_count;

  // pending result
  logic                          res_inserted;
  logic [oahi_pkg::IDX_W-1:0]    res_slot;
  logic [oahi_pkg::PROBE_W-1:0]  res_collisions;

  // combinational helpers
  logic                          cfg_wr;
  logic                          key_acc;
  logic [oahi_pkg::SIZE_W-1:0]   size_in;
  logic [oahi_pkg::MOD_W-1:0]    r_eff;
  logic [oahi_pkg::MOD_W:0]      div_trial;
  logic [oahi_pkg::MOD_W-1:0]    div_rem_next;
  logic [oahi_pkg::MOD_W-1:0]    h2;
  logic [oahi_pkg::IDX_W-1:0]    one_m;
  logic [oahi_pkg::IDX_W-1:0]    two_m;
  logic                          is_quad;
  logic                          is_double;
  logic                          slot_free;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign key_ready = (state == ST_IDLE);
  assign key_acc   = key_valid && key_ready;
  assign size_in   = oahi_pkg::eff_size(table_size);
  assign r_eff     = (second_modulus == '0) ? oahi_pkg::MOD_W'(1) : second_modulus;
  assign is_quad   = (probe_mode == oahi_pkg::MODE_QUAD);
  assign is_double = (probe_mode == oahi_pkg::MODE_DOUBLE);
  assign slot_free = !slot_valid[idx];

  // one and two reduced mod the slot count
  assign one_m = (size_q == oahi_pkg::SIZE_W'(1)) ? '0 : oahi_pkg::IDX_W'(1);
  assign two_m = (size_q <= oahi_pkg::SIZE_W'(2)) ? '0 : oahi_pkg::IDX_W'(2);

  // restoring remainder step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    div_trial    = {div_rem, div_dvd[oahi_pkg::KEY_W-1]};
    div_rem_next = div_trial[oahi_pkg::MOD_W-1:0];
    if (div_trial >= {1'b0, div_sor}) begin
      div_rem_next = oahi_pkg::MOD_W'(div_trial - {1'b0, div_sor});
    end
  end

  // second-hash step size, 1..R
  assign h2 = r_eff - div_rem_next;

  // register read mux
  always_comb begin
    unique case (paddr[3:2])
      oahi_pkg::REG_PROBE_MODE:     prdata = 32'(probe_mode);
      oahi_pkg::REG_TABLE_SIZE:     prdata = 32'(table_size);
      oahi_pkg::REG_SECOND_MODULUS: prdata = 32'(second_modulus);
      default:                      prdata = '0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode     <= oahi_pkg::PROBE_MODE_RST;
      table_size     <= oahi_pkg::TABLE_SIZE_RST;
      second_modulus <= oahi_pkg::SECOND_MOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        oahi_pkg::REG_PROBE_MODE:     probe_mode     <= pwdata[oahi_pkg::MODE_W-1:0];
        oahi_pkg::REG_TABLE_SIZE:     table_size     <= pwdata[oahi_pkg::TSIZE_W-1:0];
        oahi_pkg::REG_SECOND_MODULUS: second_modulus <= pwdata[oahi_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, remainder unit and probe loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_HOME;
      div_cnt    <= '0;
      slot_valid <= '0;
      key_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output valid: set when a result is loaded, cleared when taken
      if (state == ST_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (key_acc) begin
            key_q   <= key;
            size_q  <= size_in;
            div_dvd <= key;
            div_sor <= oahi_pkg::MOD_W'(size_in);
            div_rem <= '0;
            div_cnt <= '0;
            phase   <= PH_HOME;
            probe_i <= '0;
            hits    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == DIV_LAST) begin
            div_cnt <= '0;
            div_rem <= '0;
            unique case (phase)
              PH_HOME: begin
                idx <= div_rem_next[oahi_pkg::IDX_W-1:0];
                if (is_double) begin
                  phase   <= PH_KEYR;
                  div_dvd <= key_q;
                  div_sor <= r_eff;
                end else begin
                  delta <= one_m;
                  state <= ST_PROBE;
                end
              end
              PH_KEYR: begin
                phase   <= PH_STEP;
                div_dvd <= oahi_pkg::KEY_W'(h2);
                div_sor <= oahi_pkg::MOD_W'(size_q);
              end
              default: begin
                delta <= div_rem_next[oahi_pkg::IDX_W-1:0];
                state <= ST_PROBE;
              end
            endcase
          end else begin
            div_rem <= div_rem_next;
            div_dvd <= {div_dvd[oahi_pkg::KEY_W-2:0], 1'b0};
            div_cnt <= div_cnt + DIV_W'(1);
          end
        end
        ST_PROBE: begin
          if (slot_free) begin
            slot_valid[idx] <= 1'b1;
            if (key_count != '1) begin
              key_count <= key_count + oahi_pkg::COUNT_W'(1);
            end
            res_inserted   <= 1'b1;
            res_slot       <= idx;
            res_collisions <= hits;
            state          <= ST_RESULT;
          end else if (probe_i == PROBE_LAST) begin
            res_inserted   <= 1'b0;
            res_slot       <= '0;
            res_collisions <= PROBE_ALL;
            state          <= ST_RESULT;
          end else begin
            hits    <= hits + oahi_pkg::PROBE_W'(1);
            probe_i <= probe_i + oahi_pkg::PROBE_W'(1);
            idx     <= oahi_pkg::add_mod(idx, delta, size_q);
            if (is_quad) begin
              delta <= oahi_pkg::add_mod(delta, two_m, size_q);
            end
          end
        end
        default: begin
          // hand the item to the output register once it is free
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!out_valid || out_ready)) begin
      inserted     <= res_inserted;
      slot         <= res_slot;
      collisions   <= res_collisions;
      stored_count <= key_count;
    end
  end

  // stored count tracks the occupancy map
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(key_count) == $countones(slot_valid))
    else $error("key count differs from occupied slot count");

  // probes stay inside the slots in use
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((oahi_pkg::SIZE_W'(idx) < size_q) &&
                             (oahi_pkg::SIZE_W'(delta) < size_q)))
    else $error("probe index outside table");

  // a free slot found is taken in the next cycle
  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && slot_free) |=>
      (key_count == $past(key_count) + oahi_pkg::COUNT_W'(1)) && (state == ST_RESULT))
    else $error("store did not update count");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == ST_RESULT) |=> (state == ST_RESULT))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// File: sim/open_addressing_hash_insert_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_top_tb
// Self-checking bench for the open-addressing hash insert block. A short
// table of directed rows, with register writes and keys, is followed by
// random phases. Each phase sets the probe mode, table size and second
// modulus, then sends a burst of keys. A local table model works out every
// result, and the results are compared field by field as they leave the block.
// ----------------------------------------------------------------------------

module open_addressing_hash_insert_top_tb;

  localparam int IDLE_LIMIT   = 3000;
  localparam int PHASES       = 20;
  localparam int KEYS_PER_PH  = 55;
  localparam int MAX_LATENCY  = 110;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic                         inserted;
    logic [oahi_pkg::IDX_W-1:0]   slot;
    logic [oahi_pkg::PROBE_W-1:0] collisions;
    logic [oahi_pkg::COUNT_W-1:0] stored_count;
  } ins_result_t;

  typedef enum logic {ROW_REG, ROW_KEY} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [1:0]                 reg_idx;
    logic [31:0]                value;
    logic [oahi_pkg::KEY_W-1:0] k;
    logic                       fixed;
    ins_result_t                want;
  } dir_row_t;

  // dut signals; the inputs are known from time zero
  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [3:0]                   paddr        = '0;
  logic [31:0]                  pwdata       = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         key_valid    = 1'b0;
  logic                         key_ready;
  logic [oahi_pkg::KEY_W-1:0]   key          = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic                         inserted;
  logic [oahi_pkg::IDX_W-1:0]   slot;
  logic [oahi_pkg::PROBE_W-1:0] collisions;
  logic [oahi_pkg::COUNT_W-1:0] stored_count;

  // table model state and register mirror
  logic                         table_used [oahi_pkg::TABLE_DEPTH];
  logic [oahi_pkg::KEY_W-1:0]   table_key  [oahi_pkg::TABLE_DEPTH];
  logic [oahi_pkg::COUNT_W-1:0] held_count;
  logic [oahi_pkg::MODE_W-1:0]  cfg_mode;
  logic [oahi_pkg::TSIZE_W-1:0] cfg_size;
  logic [oahi_pkg::MOD_W-1:0]   cfg_mod;

  ins_result_t        pending_results[$];
  ins_result_t        head;
  dir_row_t           dir_rows[$];
  int                 err_count    = 0;
  int                 idle_cycles  = 0;
  int                 stall_left   = 0;
  bit                 calm         = 1'b0;

  open_addressing_hash_insert_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .key          (key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .inserted     (inserted),
    .slot         (slot),
    .collisions   (collisions),
    .stored_count (stored_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // insert one key into the table model and return the result it gives
  function automatic ins_result_t predict_insert(input logic [oahi_pkg::KEY_W-1:0] k);
    int unsigned     kk;
    int unsigned     size;
    int unsigned     home;
    int unsigned     r;
    int unsigned     idx;
    int unsigned     hits;
    longint unsigned g;
    bit              done;
    ins_result_t     res;
    kk   = k;
    size = (cfg_size == '0) ? 1 :
           (cfg_size > oahi_pkg::TABLE_DEPTH) ? oahi_pkg::TABLE_DEPTH : cfg_size;
    home = kk % size;
    hits = 0;
    done = 1'b0;
    res  = '0;
    for (int i = 0; i < oahi_pkg::MAX_PROBES; i++) begin
      if (!done) begin
        case (cfg_mode)
          oahi_pkg::MODE_QUAD: begin
            g = longint'(i) * i;
          end
          oahi_pkg::MODE_DOUBLE: begin
            r = (cfg_mod == '0) ? 1 : cfg_mod;
            g = longint'(i) * (r - kk % r);
          end
          default: begin
            g = i;
          end
        endcase
        idx = (home + int'(g % size)) % size;
        if (!table_used[idx]) begin
          table_used[idx] = 1'b1;
          table_key[idx]  = k;
          if (held_count != '1) held_count = held_count + 1'b1;
          res.inserted = 1'b1;
          res.slot     = idx[oahi_pkg::IDX_W-1:0];
          done         = 1'b1;
        end else begin
          hits++;
        end
      end
    end
    res.collisions   = hits[oahi_pkg::PROBE_W-1:0];
    res.stored_count = held_count;
    return res;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [31:0] v);
    dir_row_t row;
    row         = '{ROW_REG, idx, v, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t key_row(input logic [oahi_pkg::KEY_W-1:0] k);
    dir_row_t row;
    row = '{ROW_KEY, oahi_pkg::REG_PROBE_MODE, '0, k, 1'b0, '0};
    return row;
  endfunction

  // key row whose result is plain from the table contents
  function automatic dir_row_t key_row_want(input logic [oahi_pkg::KEY_W-1:0] k,
                                            input logic ins, input int sl,
                                            input int col, input int cnt);
    dir_row_t row;
    row = '{ROW_KEY, oahi_pkg::REG_PROBE_MODE, '0, k, 1'b1, '0};
    row.want.inserted     = ins;
    row.want.slot         = sl[oahi_pkg::IDX_W-1:0];
    row.want.collisions   = col[oahi_pkg::PROBE_W-1:0];
    row.want.stored_count = cnt[oahi_pkg::COUNT_W-1:0];
    return row;
  endfunction

  function automatic logic [oahi_pkg::KEY_W-1:0] random_key();
    logic [oahi_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0:       k = oahi_pkg::KEY_W'($urandom_range(0, 63));
      1:       k = {oahi_pkg::KEY_W{1'b1}} - oahi_pkg::KEY_W'($urandom_range(0, 63));
      default: k = oahi_pkg::KEY_W'($urandom);
    endcase
    return k;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // send one key, then record the result it should give
  task automatic send_key(input logic [oahi_pkg::KEY_W-1:0] k, input logic fixed,
                          input ins_result_t want);
    int          gap;
    ins_result_t model_res;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid <= 1'b1;
    key       <= k;
    do @(posedge clk); while (!(key_valid && key_ready));
    model_res = predict_insert(k);
    pending_results.push_back(fixed ? want : model_res);
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    key_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      oahi_pkg::REG_PROBE_MODE:     cfg_mode = v[oahi_pkg::MODE_W-1:0];
      oahi_pkg::REG_TABLE_SIZE:     cfg_size = v[oahi_pkg::TSIZE_W-1:0];
      oahi_pkg::REG_SECOND_MODULUS: cfg_mod  = v[oahi_pkg::MOD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side stalls now and then, in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result item with the oldest pending one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with none pending, slot", slot, 0);
      end else begin
        head = pending_results.pop_front();
        if (inserted !== head.inserted)
          report_mismatch("inserted", inserted, head.inserted);
        if (slot !== head.slot)
          report_mismatch("slot", slot, head.slot);
        if (collisions !== head.collisions)
          report_mismatch("collisions", collisions, head.collisions);
        if (stored_count !== head.stored_count)
          report_mismatch("stored_count", stored_count, head.stored_count);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((key_valid && key_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    cfg_mode   = oahi_pkg::PROBE_MODE_RST;
    cfg_size   = oahi_pkg::TABLE_SIZE_RST;
    cfg_mod    = oahi_pkg::SECOND_MOD_RST;
    held_count = '0;
    foreach (table_used[i]) begin
      table_used[i] = 1'b0;
      table_key[i]  = '0;
    end

    // directed rows
    // size zero acts as one slot: first key lands, second is abandoned
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 0));
    dir_rows.push_back(key_row_want('0, 1'b1, 0, 0, 1));
    dir_rows.push_back(key_row_want('1, 1'b0, 0, oahi_pkg::MAX_PROBES, 1));
    // unused mode probes linearly
    dir_rows.push_back(reg_row(oahi_pkg::REG_PROBE_MODE, 3));
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 2));
    dir_rows.push_back(key_row_want('1, 1'b1, 1, 0, 2));
    dir_rows.push_back(key_row_want(oahi_pkg::KEY_W'(5), 1'b0, 0, oahi_pkg::MAX_PROBES, 2));
    // quadratic, duplicate keys stored again
    dir_rows.push_back(reg_row(oahi_pkg::REG_PROBE_MODE, 32'(oahi_pkg::MODE_QUAD)));
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 5));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(2)));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(2)));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(7)));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(4)));
    // double hashing, modulus zero acts as one, oversized table clamps
    dir_rows.push_back(reg_row(oahi_pkg::REG_PROBE_MODE, 32'(oahi_pkg::MODE_DOUBLE)));
    dir_rows.push_back(reg_row(oahi_pkg::REG_SECOND_MODULUS, 0));
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 31));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(16)));
    dir_rows.push_back(key_row('1));
    dir_rows.push_back(reg_row(oahi_pkg::REG_SECOND_MODULUS, 65535));
    dir_rows.push_back(key_row('1));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(65534)));
    // back to full size linear, then shrink over occupied slots
    dir_rows.push_back(reg_row(oahi_pkg::REG_PROBE_MODE, 32'(oahi_pkg::MODE_LINEAR)));
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 16));
    dir_rows.push_back(key_row('1));
    dir_rows.push_back(reg_row(oahi_pkg::REG_TABLE_SIZE, 1));
    dir_rows.push_back(key_row(oahi_pkg::KEY_W'(123)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        reg_write(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_key(dir_rows[i].k, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // random phases; table sizes grow slowly so the table fills late
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      calm = (ph >= PHASES - 3) || ($urandom_range(0, 3) == 0);
      reg_write(oahi_pkg::REG_PROBE_MODE, $urandom_range(0, 3));
      reg_write(oahi_pkg::REG_TABLE_SIZE,
                (ph < 14) ? $urandom_range(0, ph + 2) : $urandom_range(0, 31));
      case ($urandom_range(0, 3))
        0:       reg_write(oahi_pkg::REG_SECOND_MODULUS, $urandom_range(0, 3));
        1:       reg_write(oahi_pkg::REG_SECOND_MODULUS, $urandom_range(1, 31));
        2:       reg_write(oahi_pkg::REG_SECOND_MODULUS, $urandom_range(1, 65535));
        default: reg_write(oahi_pkg::REG_SECOND_MODULUS, $urandom_range(65534, 65535));
      endcase
      for (int n = 0; n < KEYS_PER_PH; n++) send_key(random_key(), 1'b0, '0);
    end

    wait_idle();
    repeat (MAX_LATENCY) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/oahi_pkg.sv
rtl/open_addressing_hash_insert_top.sv
sim/open_addressing_hash_insert_top_tb.sv
